// ===== hdl/imuca_pkg.sv =====
// imuca_pkg: shared types, constants and helper functions of the attitude core
// used by every module of the design; depends on nothing

package imuca_pkg;

    // defaults and widths
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int OPD_W  = 26;   // cordic operand width, raw units
    localparam int CD_W   = 44;   // cordic working width (operand scaled by 2^16)
    localparam int ANG_W  = 26;   // angle accumulator, q16 degrees
    localparam int NUM_W  = 43;   // gyro numerator before division
    localparam int DIV_W  = 44;   // divider dividend width
    localparam int INC_W  = 34;   // gyro increment, q16 degrees
    localparam int DIVISOR = 1000;
    localparam int HALF_TURN = 11796480;   // 180 degrees in q16

    // register indexes
    typedef enum logic [2:0] {
        REG_BLEND_ALPHA = 3'd0,
        REG_GYRO_GAIN   = 3'd1,
        REG_DEF_STEP    = 3'd2,
        REG_MAX_STEP    = 3'd3,
        REG_FB_STEP     = 3'd4
    } reg_idx_t;

    localparam logic [15:0] ALPHA_RST = 16'd62915;
    localparam logic [15:0] GAIN_RST  = 16'd3996;
    localparam logic [9:0]  DEF_RST   = 10'd10;
    localparam logic [9:0]  MAX_RST   = 10'd50;
    localparam logic [9:0]  FB_RST    = 10'd20;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] gain;
        logic [9:0]  def_step;
        logic [9:0]  max_step;
        logic [9:0]  fb_step;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic start;
        logic pitch_start;
        logic blend_mul;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic sqrt_busy;
        logic cordic_busy;
        logic div_busy;
    } status_t;

    // atan(2^-i) in q16 degrees
    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:  r = 26'sd2949120;
            5'd1:  r = 26'sd1740967;
            5'd2:  r = 26'sd919879;
            5'd3:  r = 26'sd466945;
            5'd4:  r = 26'sd234379;
            5'd5:  r = 26'sd117305;
            5'd6:  r = 26'sd58666;
            5'd7:  r = 26'sd29335;
            5'd8:  r = 26'sd14668;
            5'd9:  r = 26'sd7334;
            5'd10: r = 26'sd3667;
            5'd11: r = 26'sd1833;
            5'd12: r = 26'sd917;
            5'd13: r = 26'sd458;
            5'd14: r = 26'sd229;
            5'd15: r = 26'sd115;
            5'd16: r = 26'sd57;
            5'd17: r = 26'sd29;
            5'd18: r = 26'sd14;
            5'd19: r = 26'sd7;
            5'd20: r = 26'sd4;
            5'd21: r = 26'sd2;
            5'd22: r = 26'sd1;
            default: r = 26'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/imuca_div.sv =====
// imuca_div: floor division of a signed numerator by a constant, three 16-bit
// digits by reciprocal multiplication; depends on imuca_pkg

module imuca_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [imuca_pkg::NUM_W-1:0] num,
    output logic                              busy,
    output logic signed [imuca_pkg::INC_W-1:0] quo
);
    localparam int W  = imuca_pkg::DIV_W;
    localparam int PW = 48;                          // dividend padded to three digits
    localparam logic [26:0] RECIP = 27'd68719477;    // ceil(2^36 / 1000)

    logic [PW-1:0]  dv_reg;
    logic [PW-1:0]  q_reg;
    logic [9:0]     rem_reg;
    logic [15:0]    qd_reg;
    logic [2:0]     cnt_reg;
    logic           busy_reg;
    logic           neg_reg;
    logic signed [W-1:0] n_ext;
    logic [W-1:0]   mag;
    logic [25:0]    v;
    logic [52:0]    prod;
    logic signed [imuca_pkg::INC_W-1:0] q;

    // negative numerators divide |n|+999 so the quotient rounds toward minus infinity
    assign n_ext = {num[imuca_pkg::NUM_W-1], num};
    assign mag   = num[imuca_pkg::NUM_W-1] ? W'(W'(imuca_pkg::DIVISOR - 1) - n_ext)
                                           : W'(n_ext);
    // partial dividend: remainder so far and the next digit, always below 2^26
    assign v     = {rem_reg, dv_reg[PW-1:PW-16]};
    assign prod  = 53'(v) * 53'(RECIP);
    assign q     = dv_reg[imuca_pkg::INC_W-1:0] & '0 | q_reg[imuca_pkg::INC_W-1:0];
    assign quo   = neg_reg ? -q : q;
    assign busy  = busy_reg;

    // per digit: quotient digit first, then remainder and shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd5) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[imuca_pkg::NUM_W-1];
            dv_reg  <= PW'(mag);
            q_reg   <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!cnt_reg[0]) begin
                qd_reg <= prod[51:36];
            end else begin
                rem_reg <= 10'(v - 26'(qd_reg) * 26'(imuca_pkg::DIVISOR));
                q_reg   <= {q_reg[PW-17:0], qd_reg};
                dv_reg  <= {dv_reg[PW-17:0], 16'b0};
            end
        end
    end

endmodule

// ===== hdl/imuca_cordic.sv =====
// imuca_cordic: iterative vectoring cordic giving atan2(y, x) in q16 degrees
// depends on imuca_pkg

module imuca_cordic #(
    parameter int CORDIC_STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [imuca_pkg::OPD_W-1:0] y_in,
    input  logic signed [imuca_pkg::OPD_W-1:0] x_in,
    output logic                               busy,
    output logic signed [imuca_pkg::ANG_W-1:0] ang
);
    localparam int W     = imuca_pkg::CD_W;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int EXT   = W - imuca_pkg::OPD_W - 16;

    logic signed [W-1:0] x_reg, y_reg, xw, yw, xsh, ysh;
    logic signed [imuca_pkg::ANG_W-1:0] ang_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic busy_reg;
    logic zero;

    assign xw   = {{EXT{x_in[imuca_pkg::OPD_W-1]}}, x_in, 16'b0};
    assign yw   = {{EXT{y_in[imuca_pkg::OPD_W-1]}}, y_in, 16'b0};
    assign zero = (x_in == '0) && (y_in == '0);
    assign xsh  = x_reg >>> cnt_reg;
    assign ysh  = y_reg >>> cnt_reg;
    assign busy = busy_reg;
    assign ang  = ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= !zero;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            if (zero) begin
                ang_reg <= '0;
            end else if (x_in[imuca_pkg::OPD_W-1]) begin
                // left half plane: turn by half a revolution first
                x_reg   <= -xw;
                y_reg   <= -yw;
                ang_reg <= y_in[imuca_pkg::OPD_W-1] ? -ANG_W_HALF() : ANG_W_HALF();
            end else begin
                x_reg   <= xw;
                y_reg   <= yw;
                ang_reg <= '0;
            end
        end else if (busy_reg) begin
            if (!y_reg[W-1]) begin
                x_reg   <= x_reg + ysh;
                y_reg   <= y_reg - xsh;
                ang_reg <= ang_reg + imuca_pkg::atan_tab(5'(cnt_reg));
            end else begin
                x_reg   <= x_reg - ysh;
                y_reg   <= y_reg + xsh;
                ang_reg <= ang_reg - imuca_pkg::atan_tab(5'(cnt_reg));
            end
        end
    end

    function automatic logic signed [imuca_pkg::ANG_W-1:0] ANG_W_HALF();
        return imuca_pkg::ANG_W'(imuca_pkg::HALF_TURN);
    endfunction

endmodule

// ===== hdl/imuca_ctrl.sv =====
// imuca_ctrl: sequencer for one sample and the result handshake
// depends on imuca_pkg

module imuca_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  imuca_pkg::status_t   status,
    output imuca_pkg::cmd_t      cmd
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_RUN   = 9'b000001000,
        S_SQW   = 9'b000010000,
        S_PITCH = 9'b000100000,
        S_WAIT  = 9'b001000000,
        S_BMUL  = 9'b010000000,
        S_COMMIT= 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_RUN;
            end
            S_RUN: begin
                cmd.start  = 1'b1;
                state_next = S_SQW;
            end
            S_SQW: begin
                if (!status.sqrt_busy && !status.cordic_busy) begin
                    state_next = S_PITCH;
                end
            end
            S_PITCH: begin
                cmd.pitch_start = 1'b1;
                state_next      = S_WAIT;
            end
            S_WAIT: begin
                if (!status.cordic_busy && !status.div_busy) begin
                    state_next = S_BMUL;
                end
            end
            S_BMUL: begin
                cmd.blend_mul = 1'b1;
                state_next    = S_COMMIT;
            end
            S_COMMIT: begin
                if (!valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    assign m_tvalid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hdl/imuca_dp.sv =====
// imuca_dp: datapath with time step, gyro products, square root, shared cordic,
// dividers, blend and angle state; depends on imuca_pkg, imuca_div, imuca_cordic

module imuca_dp #(
    parameter int CORDIC_STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  imuca_pkg::cfg_t      cfg,
    input  imuca_pkg::cmd_t      cmd,
    input  logic [127:0]         s_tdata,
    output imuca_pkg::status_t   status,
    output logic [95:0]          m_tdata
);
    localparam int OW = imuca_pkg::OPD_W;
    localparam int AW = imuca_pkg::ANG_W;
    localparam int IW = imuca_pkg::INC_W;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] g_reg [3];
    logic [9:0]  step_reg;
    logic [31:0] last_stamp_reg;
    logic [31:0] now_c, delta;
    logic [9:0]  step_next;

    logic signed [32:0] gp [3];
    logic signed [31:0] gprod_reg [3];
    logic signed [imuca_pkg::NUM_W-1:0] num_reg [3];
    logic [30:0] sqy_reg, sqz_reg;
    logic [31:0] sqsum_reg;
    logic signed [31:0] sqy_c, sqz_c;

    logic signed [31:0] roll_acc_reg, pitch_acc_reg, yaw_acc_reg;
    logic [95:0] out_reg;

    // square root unit
    logic [47:0] rad_reg;
    logic [25:0] srem_reg;
    logic [23:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic        sq_busy_reg;
    logic [27:0] s_try, s_trial;

    // cordic and dividers
    logic                 cor_start, cor_busy;
    logic signed [OW-1:0] cor_y, cor_x, pitch_y;
    logic signed [AW-1:0] cor_ang, acc_roll_reg;
    logic [2:0]           div_busy;
    logic signed [IW-1:0] inc [3];

    // blend
    logic signed [34:0] sum_r, sum_p, yaw_sum;
    logic [16:0]        wacc;
    logic signed [51:0] pa_r_reg, pa_p_reg;
    logic signed [43:0] pb_r_reg, pb_p_reg;
    logic signed [52:0] s_r, s_p;

    assign now_c = s_tdata[127:96];
    assign delta = now_c - last_stamp_reg;

    always_comb begin
        if (last_stamp_reg == 32'd0) begin
            step_next = cfg.def_step;
        end else if (delta > {22'd0, cfg.max_step}) begin
            step_next = cfg.fb_step;
        end else begin
            step_next = delta[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg <= '0;
        end else if (cmd.load) begin
            last_stamp_reg <= now_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg   <= s_tdata[15:0];
            ay_reg   <= s_tdata[31:16];
            az_reg   <= s_tdata[47:32];
            g_reg[0] <= s_tdata[63:48];
            g_reg[1] <= s_tdata[79:64];
            g_reg[2] <= s_tdata[95:80];
            step_reg <= step_next;
        end
    end

    // gyro rate times gain, then times step, plus half the divisor
    assign sqy_c = ay_reg * ay_reg;
    assign sqz_c = az_reg * az_reg;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign gp[k] = g_reg[k] * $signed({1'b0, cfg.gain});

        always_ff @(posedge aclk) begin
            if (cmd.mul1) begin
                gprod_reg[k] <= gp[k][31:0];
            end
            if (cmd.mul2) begin
                num_reg[k] <= imuca_pkg::NUM_W'(gprod_reg[k])
                              * imuca_pkg::NUM_W'($signed({1'b0, step_reg}))
                              + imuca_pkg::NUM_W'(imuca_pkg::DIVISOR / 2);
            end
        end

        imuca_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (cmd.start),
            .num     (num_reg[k]),
            .busy    (div_busy[k]),
            .quo     (inc[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            sqy_reg <= sqy_c[30:0];
            sqz_reg <= sqz_c[30:0];
        end
        if (cmd.mul2) begin
            sqsum_reg <= {1'b0, sqy_reg} + {1'b0, sqz_reg};
        end
    end

    // digit-by-digit square root, one result bit a cycle
    assign s_try   = {srem_reg, rad_reg[47:46]};
    assign s_trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else if (cmd.start) begin
            sq_busy_reg <= 1'b1;
            sq_cnt_reg  <= '0;
        end else if (sq_busy_reg) begin
            sq_cnt_reg <= sq_cnt_reg + 5'd1;
            if (sq_cnt_reg == 5'd23) begin
                sq_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rad_reg  <= {sqsum_reg, 16'b0};
            srem_reg <= '0;
            root_reg <= '0;
        end else if (sq_busy_reg) begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (s_try >= s_trial) begin
                srem_reg <= 26'(s_try - s_trial);
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                srem_reg <= s_try[25:0];
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    // one cordic serves roll first, then pitch once the root is known
    assign pitch_y   = -{{(OW - 24){ax_reg[15]}}, ax_reg, 8'b0};
    assign cor_start = cmd.start | cmd.pitch_start;
    assign cor_y     = cmd.pitch_start ? pitch_y : OW'(ay_reg);
    assign cor_x     = cmd.pitch_start ? $signed({{(OW - 24){1'b0}}, root_reg}) : OW'(az_reg);

    imuca_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .y_in    (cor_y),
        .x_in    (cor_x),
        .busy    (cor_busy),
        .ang     (cor_ang)
    );

    always_ff @(posedge aclk) begin
        if (cmd.pitch_start) begin
            acc_roll_reg <= cor_ang;
        end
    end

    // blend products
    assign wacc    = 17'(18'd65536 - {2'b00, cfg.alpha});
    assign sum_r   = 35'(roll_acc_reg) + 35'(inc[0]);
    assign sum_p   = 35'(pitch_acc_reg) + 35'(inc[1]);
    assign yaw_sum = 35'(yaw_acc_reg) + 35'(inc[2]);

    always_ff @(posedge aclk) begin
        if (cmd.blend_mul) begin
            pa_r_reg <= $signed({1'b0, cfg.alpha}) * sum_r;
            pa_p_reg <= $signed({1'b0, cfg.alpha}) * sum_p;
            pb_r_reg <= $signed({1'b0, wacc}) * acc_roll_reg;
            pb_p_reg <= $signed({1'b0, wacc}) * cor_ang;
        end
    end

    assign s_r = 53'(pa_r_reg) + 53'(pb_r_reg) + 53'sd32768;
    assign s_p = 53'(pa_p_reg) + 53'(pb_p_reg) + 53'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_acc_reg  <= '0;
            pitch_acc_reg <= '0;
            yaw_acc_reg   <= '0;
        end else if (cmd.commit) begin
            roll_acc_reg  <= imuca_pkg::sat32({{3{s_r[52]}}, s_r[52:16]});
            pitch_acc_reg <= imuca_pkg::sat32({{3{s_p[52]}}, s_p[52:16]});
            yaw_acc_reg   <= imuca_pkg::sat32(40'(yaw_sum));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= {imuca_pkg::sat32(40'(yaw_sum)),
                        imuca_pkg::sat32({{3{s_p[52]}}, s_p[52:16]}),
                        imuca_pkg::sat32({{3{s_r[52]}}, s_r[52:16]})};
        end
    end

    assign m_tdata            = out_reg;
    assign status.sqrt_busy   = sq_busy_reg;
    assign status.cordic_busy = cor_busy;
    assign status.div_busy    = |div_busy;

endmodule

// ===== hdl/imu_complementary_attitude_core.sv =====
// imu_complementary_attitude_core: complementary filter attitude estimator, top level
// holds the register bank; depends on imuca_pkg, imuca_ctrl, imuca_dp

// channel   direction  width  content
// s_*       in         128    one raw imu sample request
// m_*       out        96     roll, pitch and yaw in q15.16 degrees
// cfg_*     in         16     register write, no read-back
//
// from acceptance to result, the 24-step square root and then the pitch cordic
// pass set the time; the roll cordic pass and the divide by 1000 of the gyro
// increments run alongside the root.
// one sample is in flight at a time; the next is taken once the result sits in
// the output register, and a result held by m_tready stalls only the final write.
// aresetn is synchronous, active low; it clears angles and timestamp and loads the register bank defaults.

module imu_complementary_attitude_core #(
    parameter int CORDIC_STEPS = imuca_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 each), now_ms (32)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll_out, pitch_out, yaw_out (32 each)
    output logic [95:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);
    imuca_pkg::cfg_t    cfg_reg;
    imuca_pkg::cmd_t    cmd;
    imuca_pkg::status_t status;

    // register bank; indexes past the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha    <= imuca_pkg::ALPHA_RST;
            cfg_reg.gain     <= imuca_pkg::GAIN_RST;
            cfg_reg.def_step <= imuca_pkg::DEF_RST;
            cfg_reg.max_step <= imuca_pkg::MAX_RST;
            cfg_reg.fb_step  <= imuca_pkg::FB_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                imuca_pkg::REG_BLEND_ALPHA: cfg_reg.alpha    <= cfg_wdata;
                imuca_pkg::REG_GYRO_GAIN:   cfg_reg.gain     <= cfg_wdata;
                imuca_pkg::REG_DEF_STEP:    cfg_reg.def_step <= cfg_wdata[9:0];
                imuca_pkg::REG_MAX_STEP:    cfg_reg.max_step <= cfg_wdata[9:0];
                imuca_pkg::REG_FB_STEP:     cfg_reg.fb_step  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // sequencer
    imuca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and angle state
    imuca_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule
